// ----- rtl/core/smmav_pkg.sv -----
// Shared types, constants and scaling functions for the sample min/max/average voltmeter.
// Used by the interfaces, the controller, the datapath and the top level.
// Depends on nothing.
package smmav_pkg;

   // Widths of the running statistics.
   localparam int unsigned SUM_BITS   = 32;
   localparam int unsigned COUNT_BITS = 32;

   // Converter and display scaling.
   localparam int unsigned SAMPLE_BITS    = 10;
   localparam int unsigned FULL_SCALE     = 1023;
   localparam int unsigned CENTI_SPAN     = 500;
   localparam int unsigned CENTS_PER_VOLT = 100;
   localparam int unsigned CENTI_BITS     = 9;
   localparam int unsigned PROD_BITS      = SAMPLE_BITS + CENTI_BITS;
   localparam int unsigned VOLT_BITS      = 3;
   localparam int unsigned HUND_BITS      = 7;
   localparam int unsigned MAX_VOLTS      = CENTI_SPAN / CENTS_PER_VOLT;

   // Divider sizing: the mean saturates at 1023, so ten quotient bits suffice.
   localparam int unsigned QUOT_BITS = SAMPLE_BITS;
   localparam int unsigned DIV_W     = (SUM_BITS > COUNT_BITS + QUOT_BITS) ?
                                       SUM_BITS : COUNT_BITS + QUOT_BITS;
   localparam int unsigned STEP_BITS = $clog2(QUOT_BITS);

   // Request function codes.
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_CLEAR  = 1'b1;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_SCALE,
      ST_SPLIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_sample;
      logic take_clear;
      logic div_start;
      logic div_step;
      logic scale;
      logic load_out;
   } cmd_type;

   // One result as held in the output register.
   typedef struct packed {
      logic [VOLT_BITS-1:0] cur_volts;
      logic [HUND_BITS-1:0] cur_hundredths;
      logic [VOLT_BITS-1:0] min_volts;
      logic [HUND_BITS-1:0] min_hundredths;
      logic [VOLT_BITS-1:0] max_volts;
      logic [HUND_BITS-1:0] max_hundredths;
      logic [VOLT_BITS-1:0] avg_volts;
      logic [HUND_BITS-1:0] avg_hundredths;
   } result_type;

   // Centivolts of a raw reading: x*500/1023, truncated.
   // Division by 1023 uses x/1023 = x/1024 plus one correction, since the
   // remainder estimate stays below twice the divisor.
   function automatic logic [CENTI_BITS-1:0] scale_centi(input logic [SAMPLE_BITS-1:0] x);
      logic [PROD_BITS-1:0]   prod;
      logic [CENTI_BITS-1:0]  q0;
      logic [SAMPLE_BITS:0]   rem;
      prod = PROD_BITS'(x) * PROD_BITS'(CENTI_SPAN);
      q0   = prod[PROD_BITS-1:SAMPLE_BITS];
      rem  = (SAMPLE_BITS+1)'(prod[SAMPLE_BITS-1:0]) + (SAMPLE_BITS+1)'(q0);
      if (rem >= (SAMPLE_BITS+1)'(FULL_SCALE)) begin
         scale_centi = q0 + CENTI_BITS'(1);
      end else begin
         scale_centi = q0;
      end
   endfunction

   // Whole volts of a centivolt value.
   function automatic logic [VOLT_BITS-1:0] volts_of(input logic [CENTI_BITS-1:0] c);
      logic [VOLT_BITS-1:0] v;
      v = '0;
      for (int k = 1; k <= int'(MAX_VOLTS); k++) begin
         if (c >= CENTI_BITS'(k * int'(CENTS_PER_VOLT))) begin
            v = VOLT_BITS'(k);
         end
      end
      volts_of = v;
   endfunction

   // Hundredths left over once the whole volts are taken out.
   function automatic logic [HUND_BITS-1:0] hund_of(input logic [CENTI_BITS-1:0] c,
                                                    input logic [VOLT_BITS-1:0] v);
      logic [CENTI_BITS-1:0] whole;
      whole   = CENTI_BITS'(v) * CENTI_BITS'(CENTS_PER_VOLT);
      hund_of = HUND_BITS'(c - whole);
   endfunction

endpackage

// ----- rtl/core/smmav_if.sv -----
// Request and response channel interfaces for the voltmeter core.
// Depends on smmav_pkg for field widths.

// Request channel: a new sample or a clear command.
interface smmav_req_if;
   logic                                valid;
   logic                                ready;
   logic                                func;
   logic [smmav_pkg::SAMPLE_BITS-1:0]   sample;

   modport source (output valid, output func, output sample, input ready);
   modport sink   (input valid, input func, input sample, output ready);
endinterface

// Response channel: scaled current, minimum, maximum and average.
interface smmav_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [smmav_pkg::VOLT_BITS-1:0]   cur_volts;
   logic [smmav_pkg::HUND_BITS-1:0]   cur_hundredths;
   logic [smmav_pkg::VOLT_BITS-1:0]   min_volts;
   logic [smmav_pkg::HUND_BITS-1:0]   min_hundredths;
   logic [smmav_pkg::VOLT_BITS-1:0]   max_volts;
   logic [smmav_pkg::HUND_BITS-1:0]   max_hundredths;
   logic [smmav_pkg::VOLT_BITS-1:0]   avg_volts;
   logic [smmav_pkg::HUND_BITS-1:0]   avg_hundredths;

   modport source (output valid, output cur_volts, output cur_hundredths,
                   output min_volts, output min_hundredths, output max_volts,
                   output max_hundredths, output avg_volts, output avg_hundredths,
                   input ready);
   modport sink   (input valid, input cur_volts, input cur_hundredths,
                   input min_volts, input min_hundredths, input max_volts,
                   input max_hundredths, input avg_volts, input avg_hundredths,
                   output ready);
endinterface

// ----- rtl/core/sample_min_max_avg_voltmeter_core.sv -----
// Voltmeter statistics core: running minimum, maximum and average of converter samples.
// Each request carries either a 10-bit sample or a clear command; every sample
// request yields one response with the latest, lowest, highest and mean reading,
// each scaled to volts and hundredths (x*500/1023 centivolts).
// Both channels use valid/ready; a request or response moves when both are high.
// A sample request passes through a set-up state, the ten-step restoring divider,
// a scale state and a split state before its response is valid; the divider forms
// the mean one quotient bit per cycle, and no new request is accepted until the
// core is back in its idle state.
// A clear request gives no response and restores reset values.
// The response sits in an output register, so the next request is accepted while
// it waits; if the receiver still stalls when the next result is ready, the core
// holds in its final stage until the register frees.
// Reset (synchronous, active high) clears the statistics: lowest 1023, highest 0,
// latest 0, sum and count 0; no response is pending after reset.
// Depends on smmav_pkg, smmav_if, smmav_ctrl and smmav_dp.
module sample_min_max_avg_voltmeter_core (
   input  logic         clock,
   input  logic         reset,
   smmav_req_if.sink    req_chan,
   smmav_rsp_if.source  rsp_chan
);
   import smmav_pkg::*;

   cmd_type    cmd;
   result_type result;

   // Sequencing of requests, divider steps and response handshake.
   smmav_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .cmd       (cmd)
   );

   // Statistics, mean division and scaling.
   smmav_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_sample (req_chan.sample),
      .result     (result)
   );

   // Response payload.
   assign rsp_chan.cur_volts      = result.cur_volts;
   assign rsp_chan.cur_hundredths = result.cur_hundredths;
   assign rsp_chan.min_volts      = result.min_volts;
   assign rsp_chan.min_hundredths = result.min_hundredths;
   assign rsp_chan.max_volts      = result.max_volts;
   assign rsp_chan.max_hundredths = result.max_hundredths;
   assign rsp_chan.avg_volts      = result.avg_volts;
   assign rsp_chan.avg_hundredths = result.avg_hundredths;

endmodule

// ----- rtl/core/smmav_ctrl.sv -----
// Controller state machine: request handshake, divider sequencing and response valid.
// Depends on smmav_pkg for the state, command and step-count definitions.
module smmav_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_func,
   output logic                req_ready,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output smmav_pkg::cmd_type  cmd
);
   import smmav_pkg::*;

   state_type             state_ff, state_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  slot_free;
   logic                  last_step;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign last_step = (step_ff == STEP_BITS'(QUOT_BITS - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_func == FUNC_SAMPLE)) begin
               state_in = ST_START;
            end
         end
         ST_START: state_in = ST_DIV;
         ST_DIV: begin
            if (last_step) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: state_in = ST_SPLIT;
         ST_SPLIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready        = 1'b1;
            cmd.take_sample  = req_valid && (req_func == FUNC_SAMPLE);
            cmd.take_clear   = req_valid && (req_func == FUNC_CLEAR);
         end
         ST_START: cmd.div_start = 1'b1;
         ST_DIV:   cmd.div_step  = 1'b1;
         ST_SCALE: cmd.scale     = 1'b1;
         ST_SPLIT: cmd.load_out  = slot_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Divider step counter.
   always_comb begin
      step_in = step_ff;
      if (cmd.div_start) begin
         step_in = '0;
      end else if (cmd.div_step && !last_step) begin
         step_in = step_ff + STEP_BITS'(1);
      end
   end

   // The response stays valid until the receiver takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/core/smmav_dp.sv -----
// Datapath: running statistics, restoring divider for the mean, scaling and output register.
// Depends on smmav_pkg for widths, command struct and scaling functions.
module smmav_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  smmav_pkg::cmd_type                  cmd,
   input  logic [smmav_pkg::SAMPLE_BITS-1:0]   req_sample,
   output smmav_pkg::result_type               result
);
   import smmav_pkg::*;

   logic [SAMPLE_BITS-1:0] lowest_ff, lowest_in;
   logic [SAMPLE_BITS-1:0] highest_ff, highest_in;
   logic [SAMPLE_BITS-1:0] latest_ff, latest_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in, sum_base;
   logic [COUNT_BITS-1:0]  cnt_ff, cnt_in, cnt_base;

   logic [DIV_W-1:0]       rem_ff, rem_in;
   logic [DIV_W-1:0]       dvs_ff, dvs_in;
   logic [QUOT_BITS-1:0]   quot_ff, quot_in;
   logic                   sat_ff, sat_in;
   logic                   rem_ge;
   logic [SAMPLE_BITS-1:0] mean;

   logic [CENTI_BITS-1:0]  cur_c_ff, min_c_ff, max_c_ff, avg_c_ff;
   result_type             result_ff, result_in;

   // Statistics update: count and sum restart from zero when all ones.
   always_comb begin
      cnt_base   = (cnt_ff == {COUNT_BITS{1'b1}}) ? '0 : cnt_ff;
      sum_base   = (sum_ff == {SUM_BITS{1'b1}}) ? '0 : sum_ff;
      lowest_in  = lowest_ff;
      highest_in = highest_ff;
      latest_in  = latest_ff;
      sum_in     = sum_ff;
      cnt_in     = cnt_ff;
      if (cmd.take_clear) begin
         lowest_in  = SAMPLE_BITS'(FULL_SCALE);
         highest_in = '0;
         latest_in  = '0;
         sum_in     = '0;
         cnt_in     = '0;
      end else if (cmd.take_sample) begin
         cnt_in    = cnt_base + COUNT_BITS'(1);
         sum_in    = sum_base + SUM_BITS'(req_sample);
         latest_in = req_sample;
         if (req_sample < lowest_ff) begin
            lowest_in = req_sample;
         end
         if (req_sample > highest_ff) begin
            highest_in = req_sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_ff  <= SAMPLE_BITS'(FULL_SCALE);
         highest_ff <= '0;
         latest_ff  <= '0;
         sum_ff     <= '0;
         cnt_ff     <= '0;
      end else begin
         lowest_ff  <= lowest_in;
         highest_ff <= highest_in;
         latest_ff  <= latest_in;
         sum_ff     <= sum_in;
         cnt_ff     <= cnt_in;
      end
   end

   // Restoring divider, one quotient bit per cycle, most significant first.
   // A quotient of 1024 or more is detected up front and saturates.
   assign rem_ge = (rem_ff >= dvs_ff);

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      sat_in  = sat_ff;
      if (cmd.div_start) begin
         rem_in  = DIV_W'(sum_ff);
         dvs_in  = DIV_W'(cnt_ff) << (QUOT_BITS - 1);
         quot_in = '0;
         sat_in  = (DIV_W'(sum_ff) >= (DIV_W'(cnt_ff) << QUOT_BITS));
      end else if (cmd.div_step) begin
         if (rem_ge) begin
            rem_in = rem_ff - dvs_ff;
         end
         dvs_in  = dvs_ff >> 1;
         quot_in = {quot_ff[QUOT_BITS-2:0], rem_ge};
      end
   end

   assign mean = sat_ff ? SAMPLE_BITS'(FULL_SCALE) : SAMPLE_BITS'(quot_ff);

   // Divider and centivolt registers carry payload only.
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
      sat_ff  <= sat_in;
      if (cmd.scale) begin
         cur_c_ff <= scale_centi(latest_ff);
         min_c_ff <= scale_centi(lowest_ff);
         max_c_ff <= scale_centi(highest_ff);
         avg_c_ff <= scale_centi(mean);
      end
   end

   // Split centivolts into volts and hundredths for the output register.
   always_comb begin
      result_in.cur_volts      = volts_of(cur_c_ff);
      result_in.cur_hundredths = hund_of(cur_c_ff, result_in.cur_volts);
      result_in.min_volts      = volts_of(min_c_ff);
      result_in.min_hundredths = hund_of(min_c_ff, result_in.min_volts);
      result_in.max_volts      = volts_of(max_c_ff);
      result_in.max_hundredths = hund_of(max_c_ff, result_in.max_volts);
      result_in.avg_volts      = volts_of(avg_c_ff);
      result_in.avg_hundredths = hund_of(avg_c_ff, result_in.avg_volts);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ----- rtl/core/smmav_checker.sv -----
// Port-level checks for the voltmeter core, attached to the top level by bind.
// Depends on smmav_pkg for widths, function codes and display limits.
module smmav_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                req_func,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [smmav_pkg::VOLT_BITS-1:0]     cur_volts,
   input  logic [smmav_pkg::HUND_BITS-1:0]     cur_hundredths,
   input  logic [smmav_pkg::VOLT_BITS-1:0]     avg_volts,
   input  logic [smmav_pkg::HUND_BITS-1:0]     avg_hundredths
);
   import smmav_pkg::*;

   // A pending response is held until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Reset leaves no response pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A clear request never causes a response right away.
   a_clear_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == FUNC_CLEAR) |=> !$rose(rsp_valid))
      else $error("response raised by a clear request");

   // A sample request occupies the core for the following cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == FUNC_SAMPLE) |=> !req_ready)
      else $error("request accepted during division");

   // The current and average readings stay within five volts and 99 hundredths.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (cur_volts <= VOLT_BITS'(MAX_VOLTS)) &&
                    (cur_hundredths < HUND_BITS'(CENTS_PER_VOLT)) &&
                    (avg_volts <= VOLT_BITS'(MAX_VOLTS)) &&
                    (avg_hundredths < HUND_BITS'(CENTS_PER_VOLT)))
      else $error("response field out of range");

endmodule

bind sample_min_max_avg_voltmeter_core smmav_checker u_smmav_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_func       (req_chan.func),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .cur_volts      (rsp_chan.cur_volts),
   .cur_hundredths (rsp_chan.cur_hundredths),
   .avg_volts      (rsp_chan.avg_volts),
   .avg_hundredths (rsp_chan.avg_hundredths)
);

// ----- tb/smmav_scoreboard.sv -----
`timescale 1ns / 100ps
// Scoreboard for the voltmeter core: watches the request and response channels,
// predicts each response from the accepted requests and compares it field by field.
// Depends on smmav_pkg and the channel interfaces in smmav_if.
module smmav_scoreboard (
   input  logic        clock,
   input  logic        reset,
   smmav_req_if        req_mon,
   smmav_rsp_if        rsp_mon,
   output int unsigned mismatches,
   output int unsigned outstanding
);
   import smmav_pkg::*;

   localparam int unsigned REPORT_LIMIT = 10;

   // Predicted statistics, kept at the widths of the block.
   logic [SAMPLE_BITS-1:0] low_seen;
   logic [SAMPLE_BITS-1:0] high_seen;
   logic [SAMPLE_BITS-1:0] last_seen;
   logic [SUM_BITS-1:0]    total;
   logic [COUNT_BITS-1:0]  tally;

   result_type  expected_readings[$];
   int unsigned fail_count;

   // Statistics as they stand after reset or a clear request.
   function automatic void clear_statistics();
      low_seen  = SAMPLE_BITS'(FULL_SCALE);
      high_seen = '0;
      last_seen = '0;
      total     = '0;
      tally     = '0;
   endfunction

   // Scales a raw reading to centivolts (truncating) and splits it into volts and hundredths.
   function automatic void put_reading(input logic [SAMPLE_BITS-1:0] x,
                                       output logic [VOLT_BITS-1:0] volts,
                                       output logic [HUND_BITS-1:0] hundredths);
      int unsigned centi;
      centi      = x;
      centi      = centi * CENTI_SPAN / FULL_SCALE;
      volts      = VOLT_BITS'(centi / CENTS_PER_VOLT);
      hundredths = HUND_BITS'(centi % CENTS_PER_VOLT);
   endfunction

   always @(posedge clock) begin
      result_type          want;
      result_type          got;
      logic [SUM_BITS-1:0] mean;
      if (reset) begin
         clear_statistics();
         expected_readings.delete();
         fail_count = 0;
      end else begin
         // A response always belongs to an earlier request, so it is checked first.
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.cur_volts, rsp_mon.cur_hundredths,
                   rsp_mon.min_volts, rsp_mon.min_hundredths,
                   rsp_mon.max_volts, rsp_mon.max_hundredths,
                   rsp_mon.avg_volts, rsp_mon.avg_hundredths};
            if (expected_readings.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("%0t: response with no request waiting: cur %0d.%0d min %0d.%0d",
                           $time, got.cur_volts, got.cur_hundredths,
                           got.min_volts, got.min_hundredths);
               end
            end else begin
               want = expected_readings.pop_front();
               if (got.cur_volts !== want.cur_volts ||
                   got.cur_hundredths !== want.cur_hundredths ||
                   got.min_volts !== want.min_volts ||
                   got.min_hundredths !== want.min_hundredths ||
                   got.max_volts !== want.max_volts ||
                   got.max_hundredths !== want.max_hundredths ||
                   got.avg_volts !== want.avg_volts ||
                   got.avg_hundredths !== want.avg_hundredths) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("%0t: expected cur %0d.%0d min %0d.%0d max %0d.%0d avg %0d.%0d",
                              $time, want.cur_volts, want.cur_hundredths,
                              want.min_volts, want.min_hundredths,
                              want.max_volts, want.max_hundredths,
                              want.avg_volts, want.avg_hundredths);
                     $display("%0t:   actual cur %0d.%0d min %0d.%0d max %0d.%0d avg %0d.%0d",
                              $time, got.cur_volts, got.cur_hundredths,
                              got.min_volts, got.min_hundredths,
                              got.max_volts, got.max_hundredths,
                              got.avg_volts, got.avg_hundredths);
                  end
               end
            end
         end

         // An accepted request either clears the statistics or folds in a new sample.
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.func == FUNC_CLEAR) begin
               clear_statistics();
            end else begin
               // Count and sum each restart from zero once they reach all ones.
               if (tally == '1) begin
                  tally = '0;
               end
               if (total == '1) begin
                  total = '0;
               end
               tally     = tally + 1'b1;
               total     = total + SUM_BITS'(req_mon.sample);
               last_seen = req_mon.sample;
               if (req_mon.sample < low_seen) begin
                  low_seen = req_mon.sample;
               end
               if (req_mon.sample > high_seen) begin
                  high_seen = req_mon.sample;
               end

               // The mean can exceed full scale once sum and count wrap apart.
               mean = total / tally;
               if (mean > FULL_SCALE) begin
                  mean = FULL_SCALE;
               end

               put_reading(last_seen, want.cur_volts, want.cur_hundredths);
               put_reading(low_seen, want.min_volts, want.min_hundredths);
               put_reading(high_seen, want.max_volts, want.max_hundredths);
               put_reading(SAMPLE_BITS'(mean), want.avg_volts, want.avg_hundredths);
               expected_readings.push_back(want);
            end
         end
      end
      mismatches  <= fail_count;
      outstanding <= expected_readings.size();
   end

endmodule

// ----- tb/sample_min_max_avg_voltmeter_core_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the voltmeter core: clock, reset, request and response drivers
// and the final verdict. Depends on smmav_pkg, smmav_if, smmav_scoreboard and the core.
module sample_min_max_avg_voltmeter_core_tb;
   import smmav_pkg::*;

   localparam int unsigned HALF_PERIOD  = 6;
   localparam int unsigned RESET_CYCLES = 12;
   localparam int unsigned PHASE_ITEMS  = 300;
   localparam int unsigned HOLD_AFTER   = 60;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned DRAIN_CYCLES = 30;
   localparam int unsigned CYCLE_LIMIT  = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned req_idle_pct  = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned cycle_count   = 0;
   int unsigned mismatches;
   int unsigned outstanding;

   smmav_req_if req_chan();
   smmav_rsp_if rsp_chan();

   sample_min_max_avg_voltmeter_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   smmav_scoreboard scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Free-running clock, 12 ns period.
   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Run limit, counted in clock cycles.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Response receiver: random stalls, plus a long hold-off each time one is asked for.
   initial begin
      int unsigned hold_left;
      int unsigned holds_done;
      hold_left      = 0;
      holds_done     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            hold_left  = HOLD_CYCLES - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Offers one request after a random idle gap and returns at the edge that accepts it.
   // Ready is looked at on the falling edge, where it is settled for the coming edge.
   task automatic send_request(input logic op, input logic [SAMPLE_BITS-1:0] value);
      logic taken;
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.func   <= op;
      req_chan.sample <= value;
      do begin
         @(negedge clock);
         taken = req_chan.ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Stops offering requests until every predicted response has come back.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (outstanding != 0);
      @(posedge clock);
   endtask

   // Random requests: mostly samples, some pinned to the rails, some held in a narrow
   // band so that minimum and maximum settle, and an occasional clear.
   task automatic send_random(input int unsigned count);
      int unsigned pick;
      int unsigned band_low;
      band_low = $urandom_range(FULL_SCALE - 64);
      for (int unsigned n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            band_low = $urandom_range(FULL_SCALE - 64);
            send_request(FUNC_CLEAR, SAMPLE_BITS'($urandom));
         end else if (pick < 12) begin
            send_request(FUNC_SAMPLE, $urandom_range(1) ? SAMPLE_BITS'(FULL_SCALE)
                                                        : SAMPLE_BITS'(0));
         end else if (pick < 60) begin
            send_request(FUNC_SAMPLE,
                         SAMPLE_BITS'($urandom_range(band_low + 64, band_low)));
         end else begin
            send_request(FUNC_SAMPLE, SAMPLE_BITS'($urandom));
         end
      end
   endtask

   // Stimulus and verdict.
   initial begin
      req_chan.valid  = 1'b0;
      req_chan.func   = FUNC_SAMPLE;
      req_chan.sample = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed requests: clears straight out of reset and back to back, rails,
      // alternating bit patterns and readings on either side of the scaling steps.
      send_request(FUNC_CLEAR, SAMPLE_BITS'(FULL_SCALE));
      send_request(FUNC_SAMPLE, SAMPLE_BITS'(0));
      send_request(FUNC_SAMPLE, SAMPLE_BITS'(FULL_SCALE));
      send_request(FUNC_SAMPLE, SAMPLE_BITS'(512));
      send_request(FUNC_SAMPLE, SAMPLE_BITS'(511));
      send_request(FUNC_SAMPLE, SAMPLE_BITS'(1));
      send_request(FUNC_SAMPLE, SAMPLE_BITS'(1022));
      send_request(FUNC_SAMPLE, 10'h2AA);
      send_request(FUNC_SAMPLE, 10'h155);
      send_request(FUNC_CLEAR, SAMPLE_BITS'(0));
      send_request(FUNC_CLEAR, 10'h2AA);
      send_request(FUNC_SAMPLE, SAMPLE_BITS'(FULL_SCALE));
      send_request(FUNC_SAMPLE, SAMPLE_BITS'(FULL_SCALE));
      send_request(FUNC_SAMPLE, SAMPLE_BITS'(0));
      send_request(FUNC_SAMPLE, SAMPLE_BITS'(2));
      send_request(FUNC_SAMPLE, SAMPLE_BITS'(3));
      send_request(FUNC_SAMPLE, SAMPLE_BITS'(205));
      send_request(FUNC_SAMPLE, SAMPLE_BITS'(204));
      send_request(FUNC_CLEAR, 10'h155);
      send_request(FUNC_SAMPLE, SAMPLE_BITS'(614));
      wait_drained();

      // No idling; partway through, the receiver holds off while requests keep coming.
      send_random(HOLD_AFTER);
      hold_requests <= hold_requests + 1;
      send_random(PHASE_ITEMS - HOLD_AFTER);
      wait_drained();

      // Sender idle half the time.
      req_idle_pct = 50;
      send_random(PHASE_ITEMS);
      wait_drained();

      // Receiver stalling half the time.
      req_idle_pct = 0;
      rsp_stall_pct <= 50;
      send_random(PHASE_ITEMS);
      wait_drained();

      // Both sides idling.
      req_idle_pct = 37;
      rsp_stall_pct <= 37;
      send_random(PHASE_ITEMS);
      wait_drained();

      // Leave room for any stray response before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
